@@ src/wav_header_stream_parser_macros.svh @@
// Assertion macros shared by the WAV header parser modules.
`ifndef WAV_HEADER_STREAM_PARSER_MACROS_SVH
`define WAV_HEADER_STREAM_PARSER_MACROS_SVH

`ifndef ASSERT_OFF

// Same-cycle implication, disabled in reset.
`define WAVP_ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("wavp assertion failed");

// Next-cycle implication, disabled in reset.
`define WAVP_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("wavp assertion failed");

`else

`define WAVP_ASSERT_IMPLY(label, clk, rst, ante, cons)
`define WAVP_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

@@ src/wavp_pkg.sv @@
package wavp_pkg;

  // One input transfer: a file byte and its end-of-file mark
  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_file;
  } in_item_t;

  // One result transfer
  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  pcm_byte;
    logic        data_done;
    logic [2:0]  status;
    logic [15:0] channel_count;
    logic [31:0] rate_hz;
    logic        sample_kind;
    logic [31:0] data_length;
  } out_item_t;

  // Parser phases
  typedef enum logic [3:0] {
    PH_HEAD    = 4'd0,
    PH_FMTID   = 4'd1,
    PH_FMTSIZE = 4'd2,
    PH_FMTBODY = 4'd3,
    PH_FMTSKIP = 4'd4,
    PH_CHID    = 4'd5,
    PH_CHSIZE  = 4'd6,
    PH_SKIP    = 4'd7,
    PH_DATA    = 4'd8,
    PH_FAIL    = 4'd9,
    PH_TAIL    = 4'd10
  } phase_t;

  // Result kinds
  localparam logic [1:0] KIND_PCM    = 2'd0;
  localparam logic [1:0] KIND_REPORT = 2'd1;
  localparam logic [1:0] KIND_FAIL   = 2'd2;

  // Status codes
  localparam logic [2:0] ST_OK          = 3'd0;
  localparam logic [2:0] ST_NOT_WAVE    = 3'd1;
  localparam logic [2:0] ST_NO_FMT      = 3'd2;
  localparam logic [2:0] ST_NO_DATA     = 3'd3;
  localparam logic [2:0] ST_UNSUPPORTED = 3'd4;

  // Tags, first file byte in the low byte
  localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
  localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
  localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;
  localparam logic [31:0] TAG_DATA = 32'h6174_6164;

  // Captured format body length and header lengths, in bytes
  localparam logic [5:0]  HEAD_LEN      = 6'd12;
  localparam logic [5:0]  TAG_LEN       = 6'd4;
  localparam logic [5:0]  FMT_BODY_LEN  = 6'd16;
  localparam logic [31:0] FMT_BODY_LEN32 = 32'd16;

  // Format fields
  localparam logic [15:0] FMT_PCM  = 16'd1;
  localparam logic [15:0] BITS_8   = 16'd8;
  localparam logic [15:0] BITS_16  = 16'd16;

endpackage

@@ src/wavp_in_stage.sv @@
module wavp_in_stage (
  input  logic               clk,
  input  logic               rst,
  input  logic               byte_valid,
  output logic               byte_ready,
  input  wavp_pkg::in_item_t byte_item,
  input  logic               take,
  output logic               hold_valid,
  output wavp_pkg::in_item_t hold_item
);
  import wavp_pkg::*;

  // Open for a new transfer when empty or when the held byte moves on
  assign byte_ready = !hold_valid || take;

  // Hold valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (byte_ready) begin
      hold_valid <= byte_valid;
    end
  end

  // Capture the byte
  always_ff @(posedge clk) begin
    if (byte_valid && byte_ready) begin
      hold_item <= byte_item;
    end
  end

endmodule

@@ src/wavp_parse.sv @@
`include "wav_header_stream_parser_macros.svh"

module wavp_parse (
  input  logic                clk,
  input  logic                rst,
  input  logic                fire,
  input  wavp_pkg::in_item_t  cur,
  output logic                has_result,
  output wavp_pkg::out_item_t result
);
  import wavp_pkg::*;

  phase_t      phase, phase_next;
  logic [5:0]  byte_index, byte_index_next;
  logic [31:0] remaining, remaining_next;
  logic [31:0] gather, gather_next;
  logic [15:0] format_code, format_code_next;
  logic [15:0] channels_seen, channels_seen_next;
  logic [31:0] rate_seen, rate_seen_next;
  logic [15:0] bits_seen, bits_seen_next;

  logic [5:0]  idx_inc;
  logic [31:0] byte_sh;
  logic [15:0] byte_sh16;
  logic [31:0] rem_new;
  logic [31:0] rem_dec;
  logic        fmt_ok;
  logic        report;
  logic        mismatch;

  assign idx_inc   = byte_index + 6'd1;
  assign byte_sh   = {24'd0, cur.in_byte} << {byte_index[1:0], 3'b000};
  assign byte_sh16 = {8'd0, cur.in_byte} << {byte_index[0], 3'b000};
  assign rem_new   = remaining | byte_sh;
  assign rem_dec   = remaining - 32'd1;
  assign fmt_ok    = (format_code == FMT_PCM) &&
                     ((bits_seen == BITS_8) || (bits_seen == BITS_16));

  // Compare the current byte against the RIFF/WAVE header
  always_comb begin
    mismatch = 1'b0;
    if (byte_index < 6'd4) begin
      mismatch = cur.in_byte != TAG_RIFF[{byte_index[1:0], 3'b000} +: 8];
    end else if (byte_index >= 6'd8) begin
      mismatch = cur.in_byte != TAG_WAVE[{byte_index[1:0], 3'b000} +: 8];
    end
  end

  // Next state and result for one byte
  always_comb begin
    phase_next         = phase;
    byte_index_next    = byte_index;
    remaining_next     = remaining;
    gather_next        = gather;
    format_code_next   = format_code;
    channels_seen_next = channels_seen;
    rate_seen_next     = rate_seen;
    bits_seen_next     = bits_seen;
    result             = '0;
    has_result         = 1'b0;
    report             = 1'b0;

    case (phase)
      PH_HEAD: begin
        if (mismatch) begin
          result.kind   = KIND_FAIL;
          result.status = ST_NOT_WAVE;
          has_result    = 1'b1;
          phase_next    = PH_FAIL;
        end else if (idx_inc >= HEAD_LEN) begin
          phase_next      = PH_FMTID;
          byte_index_next = '0;
        end else begin
          byte_index_next = idx_inc;
        end
      end
      PH_FMTID: begin
        if (cur.in_byte != TAG_FMT[{byte_index[1:0], 3'b000} +: 8]) begin
          result.kind   = KIND_FAIL;
          result.status = ST_NO_FMT;
          has_result    = 1'b1;
          phase_next    = PH_FAIL;
        end else if (idx_inc >= TAG_LEN) begin
          phase_next      = PH_FMTSIZE;
          byte_index_next = '0;
          remaining_next  = '0;
        end else begin
          byte_index_next = idx_inc;
        end
      end
      PH_FMTSIZE: begin
        remaining_next = rem_new;
        if (idx_inc >= TAG_LEN) begin
          phase_next      = PH_FMTBODY;
          byte_index_next = '0;
        end else begin
          byte_index_next = idx_inc;
        end
      end
      PH_FMTBODY: begin
        // Capture code, channels, rate and bits; skip the rest of the body
        if (byte_index < 6'd2) begin
          format_code_next = format_code | byte_sh16;
        end else if (byte_index < 6'd4) begin
          channels_seen_next = channels_seen | byte_sh16;
        end else if (byte_index < 6'd8) begin
          rate_seen_next = rate_seen | byte_sh;
        end else if (byte_index >= 6'd14) begin
          bits_seen_next = bits_seen | byte_sh16;
        end
        if (idx_inc >= FMT_BODY_LEN) begin
          byte_index_next = '0;
          gather_next     = '0;
          if (remaining > FMT_BODY_LEN32) begin
            remaining_next = remaining - FMT_BODY_LEN32;
            phase_next     = PH_FMTSKIP;
          end else begin
            phase_next = PH_CHID;
          end
        end else begin
          byte_index_next = idx_inc;
        end
      end
      PH_FMTSKIP, PH_SKIP: begin
        remaining_next = rem_dec;
        if (rem_dec == 32'd0) begin
          phase_next      = PH_CHID;
          gather_next     = '0;
          byte_index_next = '0;
        end
      end
      PH_CHID: begin
        gather_next = gather | byte_sh;
        if (idx_inc >= TAG_LEN) begin
          phase_next      = PH_CHSIZE;
          byte_index_next = '0;
          remaining_next  = '0;
        end else begin
          byte_index_next = idx_inc;
        end
      end
      PH_CHSIZE: begin
        remaining_next = rem_new;
        if (idx_inc >= TAG_LEN) begin
          byte_index_next = '0;
          if (gather == TAG_DATA) begin
            report               = 1'b1;
            has_result           = 1'b1;
            result.kind          = KIND_REPORT;
            result.status        = fmt_ok ? ST_OK : ST_UNSUPPORTED;
            result.channel_count = channels_seen;
            result.rate_hz       = rate_seen;
            result.sample_kind   = fmt_ok && (bits_seen == BITS_16);
            result.data_length   = rem_new;
            if (!fmt_ok) begin
              phase_next = PH_FAIL;
            end else if (rem_new == 32'd0) begin
              phase_next = PH_TAIL;
            end else begin
              phase_next = PH_DATA;
            end
          end else if (rem_new == 32'd0) begin
            phase_next  = PH_CHID;
            gather_next = '0;
          end else begin
            phase_next = PH_SKIP;
          end
        end else begin
          byte_index_next = idx_inc;
        end
      end
      PH_DATA: begin
        has_result      = 1'b1;
        result.kind     = KIND_PCM;
        result.pcm_byte = cur.in_byte;
        remaining_next  = rem_dec;
        if (rem_dec == 32'd0) begin
          result.data_done = 1'b1;
          phase_next       = PH_TAIL;
        end else if (cur.end_of_file) begin
          result.data_done = 1'b1;
          result.status    = ST_NO_DATA;
        end
      end
      PH_FAIL, PH_TAIL: begin
      end
      default: begin
        phase_next = PH_FAIL;
      end
    endcase

    // End of file: flag truncation, then return to the start
    if (cur.end_of_file) begin
      if (report && (phase_next == PH_DATA)) begin
        result.status = ST_NO_DATA;
      end else if (!has_result && (phase != PH_DATA) && (phase != PH_FAIL) &&
                   (phase != PH_TAIL)) begin
        has_result    = 1'b1;
        result.kind   = KIND_FAIL;
        result.status = ST_NO_DATA;
      end
      phase_next         = PH_HEAD;
      byte_index_next    = '0;
      remaining_next     = '0;
      gather_next        = '0;
      format_code_next   = '0;
      channels_seen_next = '0;
      rate_seen_next     = '0;
      bits_seen_next     = '0;
    end
  end

  // Advance parser state on each consumed byte
  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_HEAD;
      byte_index    <= '0;
      remaining     <= '0;
      gather        <= '0;
      format_code   <= '0;
      channels_seen <= '0;
      rate_seen     <= '0;
      bits_seen     <= '0;
    end else if (fire) begin
      phase         <= phase_next;
      byte_index    <= byte_index_next;
      remaining     <= remaining_next;
      gather        <= gather_next;
      format_code   <= format_code_next;
      channels_seen <= channels_seen_next;
      rate_seen     <= rate_seen_next;
      bits_seen     <= bits_seen_next;
    end
  end

  `WAVP_ASSERT_NEXT(a_eof_restart, clk, rst, fire && cur.end_of_file, (phase == PH_HEAD) && (byte_index == 6'd0) && (remaining == 32'd0))
  `WAVP_ASSERT_IMPLY(a_index_bound, clk, rst, 1'b1, byte_index <= FMT_BODY_LEN)
  `WAVP_ASSERT_IMPLY(a_data_nonzero, clk, rst, phase == PH_DATA, remaining != 32'd0)

endmodule

@@ src/wavp_out_stage.sv @@
`include "wav_header_stream_parser_macros.svh"

module wavp_out_stage (
  input  logic                clk,
  input  logic                rst,
  input  logic                load,
  input  wavp_pkg::out_item_t load_item,
  output logic                free,
  output logic                rpt_valid,
  input  logic                rpt_ready,
  output wavp_pkg::out_item_t rpt_item
);
  import wavp_pkg::*;

  // Slot can take a new result when empty or being drained
  assign free = !rpt_valid || rpt_ready;

  // Result valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      rpt_valid <= 1'b0;
    end else if (load) begin
      rpt_valid <= 1'b1;
    end else if (rpt_ready) begin
      rpt_valid <= 1'b0;
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (load) begin
      rpt_item <= load_item;
    end
  end

  `WAVP_ASSERT_IMPLY(a_no_overwrite, clk, rst, load, !rpt_valid || rpt_ready)
  `WAVP_ASSERT_NEXT(a_hold_valid, clk, rst, rpt_valid && !rpt_ready, rpt_valid)
  `WAVP_ASSERT_NEXT(a_hold_item, clk, rst, rpt_valid && !rpt_ready, $stable(rpt_item))

endmodule

@@ src/wav_header_stream_parser.sv @@
// Channel  Direction  Handshake                Payload
// byte     in         byte_valid / byte_ready  byte_item  (in_item_t)
// rpt      out        rpt_valid / rpt_ready    rpt_item   (out_item_t)
//
// One byte per cycle while the result register can accept: a byte is held in the
// input register, then the parser logic updates its state and loads the result
// register in one step.
// rst is synchronous; the parser restarts at the RIFF tag after reset and
// after every end-of-file byte.
// A result waiting in the output register holds the byte in the input register,
// even one that makes no result, and the input closes while that register is full.
module wav_header_stream_parser (
  input  logic                clk,
  input  logic                rst,
  input  logic                byte_valid,
  output logic                byte_ready,
  input  wavp_pkg::in_item_t  byte_item,
  output logic                rpt_valid,
  input  logic                rpt_ready,
  output wavp_pkg::out_item_t rpt_item
);
  import wavp_pkg::*;

  logic      hold_valid;
  in_item_t  hold_item;
  logic      take;
  logic      free;
  logic      has_result;
  out_item_t result;

  // Consume the held byte when the result slot can accept
  assign take = hold_valid && free;

  wavp_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .byte_valid (byte_valid),
    .byte_ready (byte_ready),
    .byte_item  (byte_item),
    .take       (take),
    .hold_valid (hold_valid),
    .hold_item  (hold_item)
  );

  wavp_parse u_parse (
    .clk        (clk),
    .rst        (rst),
    .fire       (take),
    .cur        (hold_item),
    .has_result (has_result),
    .result     (result)
  );

  wavp_out_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (take && has_result),
    .load_item (result),
    .free      (free),
    .rpt_valid (rpt_valid),
    .rpt_ready (rpt_ready),
    .rpt_item  (rpt_item)
  );

endmodule
